// File: rtl/core/wmft_pkg.sv
package wmft_pkg;

  // Window geometry
  localparam int VALUE_BITS = 12;
  localparam int MAX_WINDOW = 4096;
  localparam int NVALUES    = 1 << VALUE_BITS;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 12;
  localparam int K_W     = 13;
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int HADDR_BITS = $clog2(MAX_WINDOW);
  localparam int PROD_W     = CNT_BITS + K_W;

  // Clear sweep covers the deeper of the two tables
  localparam int CLR_DEPTH = (NVALUES > MAX_WINDOW) ? NVALUES : MAX_WINDOW;
  localparam int CLR_BITS  = $clog2(CLR_DEPTH);

  // Stream data widths, padded to whole bytes
  localparam int IN_RAW_W     = FUNC_W + VALUE_W + K_W;
  localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W    = 2 * CNT_BITS + 2;
  localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QRY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic rdc;
    logic wr1;
    logic wr2;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic skip;
  } sts_t;

endpackage

// File: rtl/core/window_mode_frequency_tracker.sv
// Channel | Dir | tdata fields (low bit up)                          | tuser
// in_     | in  | func[1:0] value[13:2] ratio_k[26:14], zero to 31   | none
// out_    | out | max_freq[12:0] window_size[25:13] dominant[26]
//         |     | error[27], zero to 31                               | none
//
// After reset both tables are swept to zero with in_tready low.
// An add or remove steps through transfer, count update with histogram read,
// two histogram writes on the single histogram write port, then output load.
// A query or a flagged item skips the two histogram writes.
// The result register holds while out_tready is low; the next item is taken
// meanwhile and waits in its last step until the register frees.
module window_mode_frequency_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wmft_pkg::IN_TDATA_W-1:0]   in_tdata,   // func, value, ratio_k
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wmft_pkg::OUT_TDATA_W-1:0]  out_tdata   // max_freq, window_size,
                                                        // dominant, error
);

  wmft_pkg::cmd_t cmd;
  wmft_pkg::sts_t sts;

  // Sequencer
  wmft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Tables, window state and result register
  wmft_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: rtl/core/wmft_dp.sv
module wmft_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [wmft_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wmft_pkg::cmd_t                     cmd,
  output wmft_pkg::sts_t                     sts,
  output logic [wmft_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int VB = wmft_pkg::VALUE_BITS;
  localparam int CB = wmft_pkg::CNT_BITS;
  localparam int HB = wmft_pkg::HADDR_BITS;
  localparam int KB = wmft_pkg::K_W;
  localparam int LB = wmft_pkg::CLR_BITS;
  localparam int FB = wmft_pkg::FUNC_W;

  // Tables
  logic [CB-1:0] vc_mem   [wmft_pkg::NVALUES];
  logic [CB-1:0] hist_mem [wmft_pkg::MAX_WINDOW];

  // Latched item
  logic [FB-1:0] func_r;
  logic [VB-1:0] vaddr_r;
  logic [KB-1:0] k_r;

  // Window state
  logic [CB-1:0] top_r, top_nxt;
  logic [CB-1:0] size_r, size_nxt;
  logic [LB-1:0] clr_addr_r;

  // Per-item working registers
  logic [CB-1:0] vc_rd_r;
  logic [CB-1:0] h0_r, h1_r;
  logic [CB-1:0] c_r, n_r;
  logic          add_r;
  logic          err_r;

  // Output register fields
  logic [CB-1:0] out_max_r, out_size_r;
  logic          out_dom_r, out_err_r;

  // Input field split
  logic [FB-1:0] in_func;
  logic [VB-1:0] in_vaddr;
  logic [KB-1:0] in_k;

  assign in_func  = in_tdata[FB-1:0];
  assign in_vaddr = in_tdata[FB +: VB];
  assign in_k     = in_tdata[FB+wmft_pkg::VALUE_W +: KB];

  // Count lookup decode
  logic          is_add, is_rem, err_c, skip_c;
  logic [CB-1:0] cnt_inc, cnt_dec, cnt_dec2;
  logic [HB-1:0] hra0, hra1;

  always_comb begin
    is_add   = (func_r == wmft_pkg::FUNC_ADD);
    is_rem   = (func_r == wmft_pkg::FUNC_REM);
    err_c    = (is_add && (size_r == CB'(wmft_pkg::MAX_WINDOW))) ||
               (is_rem && (vc_rd_r == '0));
    skip_c   = err_c || !(is_add || is_rem);
    cnt_inc  = vc_rd_r + 1'b1;
    cnt_dec  = vc_rd_r - 1'b1;
    cnt_dec2 = vc_rd_r - CB'(2);
    hra0     = cnt_dec[HB-1:0];
    hra1     = is_add ? vc_rd_r[HB-1:0] : cnt_dec2[HB-1:0];
  end

  assign sts.skip     = skip_c;
  assign sts.clr_done = (clr_addr_r == LB'(wmft_pkg::CLR_DEPTH - 1));

  // Hold the item fields at the transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r  <= in_func;
      vaddr_r <= in_vaddr;
      k_r     <= in_k;
    end
  end

  // Count table: one write port, one registered read port
  logic          vc_we;
  logic [VB-1:0] vc_wa;
  logic [CB-1:0] vc_wd;

  always_comb begin
    vc_we = 1'b0;
    vc_wa = vaddr_r;
    vc_wd = '0;
    if (cmd.clr_step) begin
      vc_we = ({1'b0, clr_addr_r} < (LB+1)'(wmft_pkg::NVALUES));
      vc_wa = clr_addr_r[VB-1:0];
      vc_wd = '0;
    end else if (cmd.rdc) begin
      vc_we = !skip_c;
      vc_wa = vaddr_r;
      vc_wd = is_add ? cnt_inc : cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (vc_we) begin
      vc_mem[vc_wa] <= vc_wd;
    end
    if (cmd.accept) begin
      vc_rd_r <= vc_mem[in_vaddr];
    end
  end

  // Histogram: bin c lives at address c-1; one write port, two read ports
  logic          h_we;
  logic [HB-1:0] h_wa;
  logic [CB-1:0] h_wd;
  logic [CB-1:0] c_dec, n_dec;

  assign c_dec = c_r - 1'b1;
  assign n_dec = n_r - 1'b1;

  always_comb begin
    h_we = 1'b0;
    h_wa = c_dec[HB-1:0];
    h_wd = '0;
    if (cmd.clr_step) begin
      h_we = ({1'b0, clr_addr_r} < (LB+1)'(wmft_pkg::MAX_WINDOW));
      h_wa = clr_addr_r[HB-1:0];
      h_wd = '0;
    end else if (cmd.wr1) begin
      h_we = (c_r != '0);
      h_wa = c_dec[HB-1:0];
      h_wd = h0_r - 1'b1;
    end else if (cmd.wr2) begin
      h_we = (n_r != '0);
      h_wa = n_dec[HB-1:0];
      h_wd = h1_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    if (cmd.rdc) begin
      h0_r <= hist_mem[hra0];
      h1_r <= hist_mem[hra1];
    end
  end

  // Capture old and new count and the error flag
  always_ff @(posedge clk) begin
    if (cmd.rdc) begin
      c_r   <= vc_rd_r;
      n_r   <= is_add ? cnt_inc : cnt_dec;
      add_r <= is_add;
      err_r <= err_c;
    end
  end

  // Top frequency and size update; top drops when its bin empties
  always_comb begin
    top_nxt  = top_r;
    size_nxt = size_r;
    if (cmd.wr1) begin
      if (add_r) begin
        if (n_r > top_r) begin
          top_nxt = n_r;
        end
        size_nxt = size_r + 1'b1;
      end else begin
        if ((c_r == top_r) && (h0_r == CB'(1))) begin
          top_nxt = top_r - 1'b1;
        end
        size_nxt = size_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      size_r     <= '0;
      clr_addr_r <= '0;
    end else begin
      top_r  <= top_nxt;
      size_r <= size_nxt;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Dominance test and output register
  logic [wmft_pkg::PROD_W-1:0] prod;

  assign prod = wmft_pkg::PROD_W'(top_r) * wmft_pkg::PROD_W'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_max_r  <= top_r;
      out_size_r <= size_r;
      out_dom_r  <= (prod >= wmft_pkg::PROD_W'(size_r));
      out_err_r  <= err_r;
    end
  end

  assign out_tdata = wmft_pkg::OUT_TDATA_W'({out_err_r, out_dom_r, out_size_r, out_max_r});

  // The top frequency never exceeds the window size
  a_top_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= size_r)
    else $error("top frequency above window size");

  // The window never grows past its limit
  a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CB'(wmft_pkg::MAX_WINDOW))
    else $error("window size above limit");

  // Size changes only in the first histogram write step
  a_size_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.wr1 |=> (size_r == $past(size_r)))
    else $error("window size changed outside update");

  // An error item leaves the window untouched
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rdc && err_c) |=> ((size_r == $past(size_r)) && (top_r == $past(top_r))))
    else $error("error item changed the window");

endmodule

// File: rtl/core/wmft_ctrl.sv
module wmft_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  wmft_pkg::sts_t  sts,
  output wmft_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDC  = 3'd2;
  localparam logic [2:0] S_WR1  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;

  assign out_free = !out_tvalid_r || out_tready;

  // Clear, then lookup, two histogram writes unless skipped, output
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RDC;
        end
      end
      S_RDC: begin
        cmd.rdc   = 1'b1;
        state_nxt = sts.skip ? S_OUT : S_WR1;
      end
      S_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr2   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Hold the result until the downstream transfer
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  // An accepted item goes straight to the count lookup
  a_accept_rdc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_RDC))
    else $error("accepted item did not reach lookup");

  // No item is taken while the tables are being cleared
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !cmd.accept)
    else $error("item accepted during clear");

  // A result load always leaves a valid result behind
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

// File: test/tb.sv
module tb;

  localparam logic [wmft_pkg::FUNC_W-1:0] FUNC_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE = 6;

  typedef struct packed {
    logic [wmft_pkg::FUNC_W-1:0]  func;
    logic [wmft_pkg::VALUE_W-1:0] value;
    logic [wmft_pkg::K_W-1:0]     ratio_k;
  } window_item_t;

  typedef struct packed {
    logic [wmft_pkg::CNT_BITS-1:0] max_freq;
    logic [wmft_pkg::CNT_BITS-1:0] window_size;
    logic                          dominant;
    logic                          error;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [wmft_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [wmft_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the window contents
  int unsigned value_occ [wmft_pkg::NVALUES];
  int unsigned count_bins [wmft_pkg::MAX_WINDOW+1];
  int unsigned top_count = 0;
  int unsigned window_fill = 0;

  window_item_t   pending_items [$];
  window_result_t expected_results [$];

  logic in_taken = 1'b0;
  int send_gap_pct;
  int recv_gap_pct;
  int mismatches = 0;
  int quiet_cycles = 0;

  window_mode_frequency_tracker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Apply one item to the mirrored window and return the reported state
  function automatic window_result_t update_window(window_item_t item);
    int unsigned cnt;
    window_result_t res;
    logic flagged;
    flagged = 1'b0;
    case (item.func)
      wmft_pkg::FUNC_ADD: begin
        if (window_fill >= wmft_pkg::MAX_WINDOW) begin
          flagged = 1'b1;
        end else begin
          cnt = value_occ[item.value];
          if (cnt > 0) count_bins[cnt]--;
          cnt++;
          value_occ[item.value] = cnt;
          count_bins[cnt]++;
          if (cnt > top_count) top_count = cnt;
          window_fill++;
        end
      end
      wmft_pkg::FUNC_REM: begin
        cnt = value_occ[item.value];
        if (cnt == 0) begin
          flagged = 1'b1;
        end else begin
          count_bins[cnt]--;
          cnt--;
          value_occ[item.value] = cnt;
          if (cnt > 0) count_bins[cnt]++;
          if (top_count > 0 && count_bins[top_count] == 0) top_count--;
          window_fill--;
        end
      end
      default: ;
    endcase
    res.max_freq    = top_count[wmft_pkg::CNT_BITS-1:0];
    res.window_size = window_fill[wmft_pkg::CNT_BITS-1:0];
    res.dominant    = (longint'(top_count) * longint'(item.ratio_k)) >= longint'(window_fill);
    res.error       = flagged;
    return res;
  endfunction

  // Present items and randomize result backpressure on the falling edge
  always @(negedge clk) begin : driver
    window_item_t nxt;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
      if (!in_tvalid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_items.pop_front();
          in_tdata  <= wmft_pkg::IN_TDATA_W'({nxt.ratio_k, nxt.value, nxt.func});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin : monitor
    window_item_t   seen;
    window_result_t want;
    window_result_t got;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.max_freq    = out_tdata[12:0];
      got.window_size = out_tdata[25:13];
      got.dominant    = out_tdata[26];
      got.error       = out_tdata[27];
      if (expected_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.max_freq !== want.max_freq) begin
          $error("max_freq: expected %0d, got %0d", want.max_freq, got.max_freq);
          mismatches++;
        end
        if (got.window_size !== want.window_size) begin
          $error("window_size: expected %0d, got %0d", want.window_size, got.window_size);
          mismatches++;
        end
        if (got.dominant !== want.dominant) begin
          $error("dominant: expected %0d, got %0d", want.dominant, got.dominant);
          mismatches++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, got.error);
          mismatches++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      seen.func    = in_tdata[1:0];
      seen.value   = in_tdata[13:2];
      seen.ratio_k = in_tdata[26:14];
      expected_results.insert(expected_results.size(), update_window(seen));
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_item(logic [wmft_pkg::FUNC_W-1:0] func,
                            logic [wmft_pkg::VALUE_W-1:0] value,
                            logic [wmft_pkg::K_W-1:0] ratio_k);
    window_item_t item;
    item.func    = func;
    item.value   = value;
    item.ratio_k = ratio_k;
    pending_items.insert(pending_items.size(), item);
  endtask

  function automatic logic [wmft_pkg::K_W-1:0] pick_ratio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return wmft_pkg::K_W'($urandom_range(8));
    if (sel < 80) return wmft_pkg::K_W'($urandom_range(8191));
    case ($urandom_range(2))
      0:       return '0;
      1:       return wmft_pkg::K_W'(4096);
      default: return '1;
    endcase
  endfunction

  // Mostly adds and removes over a small value pool, so counts pile up
  task automatic queue_random(int n);
    logic [wmft_pkg::VALUE_W-1:0] pool [POOL_SIZE];
    logic [wmft_pkg::VALUE_W-1:0] val;
    logic [wmft_pkg::FUNC_W-1:0] func;
    int sel;
    foreach (pool[i]) pool[i] = wmft_pkg::VALUE_W'($urandom_range(4095));
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45)      func = wmft_pkg::FUNC_ADD;
      else if (sel < 80) func = wmft_pkg::FUNC_REM;
      else if (sel < 93) func = wmft_pkg::FUNC_QRY;
      else               func = FUNC_RSVD;
      if ($urandom_range(9) == 0) val = wmft_pkg::VALUE_W'($urandom_range(4095));
      else                        val = pool[$urandom_range(POOL_SIZE-1)];
      queue_item(func, val, pick_ratio());
    end
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    send_gap_pct = 20;
    recv_gap_pct = 57;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Empty window, absent removes, reserved code, then small bins
    queue_item(wmft_pkg::FUNC_QRY, 12'h000, 13'd0);
    queue_item(wmft_pkg::FUNC_REM, 12'h000, 13'd5);
    queue_item(FUNC_RSVD,          12'hFFF, 13'h1FFF);
    queue_item(wmft_pkg::FUNC_ADD, 12'h000, 13'd0);
    queue_item(wmft_pkg::FUNC_ADD, 12'hFFF, 13'h1FFF);
    queue_item(wmft_pkg::FUNC_ADD, 12'hFFF, 13'd1);
    queue_item(wmft_pkg::FUNC_QRY, 12'h123, 13'd4096);
    queue_item(wmft_pkg::FUNC_REM, 12'hFFF, 13'd1);
    queue_item(wmft_pkg::FUNC_REM, 12'h000, 13'd2);
    queue_item(wmft_pkg::FUNC_REM, 12'h000, 13'd2);
    queue_item(wmft_pkg::FUNC_ADD, 12'hAAA, 13'h0AAA);
    queue_item(wmft_pkg::FUNC_ADD, 12'h555, 13'h1555);
    queue_item(wmft_pkg::FUNC_ADD, 12'hAAA, 13'd1);
    queue_item(wmft_pkg::FUNC_REM, 12'h555, 13'd1);
    queue_item(wmft_pkg::FUNC_REM, 12'hAAA, 13'd1);
    queue_item(FUNC_RSVD,          12'h5A5, 13'd0);
    queue_item(wmft_pkg::FUNC_REM, 12'hAAA, 13'd3);
    queue_item(wmft_pkg::FUNC_REM, 12'hFFF, 13'd0);
    queue_item(wmft_pkg::FUNC_QRY, 12'h000, 13'd0);
    queue_random(140);
    wait_drained();

    send_gap_pct = 57;
    recv_gap_pct = 20;
    queue_random(140);
    wait_drained();

    // Back to back with no idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    queue_item(wmft_pkg::FUNC_ADD, 12'h800, 13'd1);
    queue_item(wmft_pkg::FUNC_ADD, 12'h123, 13'd0);
    queue_item(wmft_pkg::FUNC_QRY, 12'h000, 13'h1FFF);
    queue_item(wmft_pkg::FUNC_REM, 12'h001, 13'd4096);
    queue_random(150);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
